### src/lcdns_pkg.sv
package lcdns_pkg;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_INIT = 3'd1;
    localparam logic [2:0] OP_CMD  = 3'd2;
    localparam logic [2:0] OP_CHAR = 3'd3;
    localparam logic [2:0] OP_POS  = 3'd4;

    localparam logic [2:0] CFG_POWER_UP  = 3'd0;
    localparam logic [2:0] CFG_SETUP     = 3'd1;
    localparam logic [2:0] CFG_PULSE     = 3'd2;
    localparam logic [2:0] CFG_SETTLE    = 3'd3;
    localparam logic [2:0] CFG_CHAR_XTRA = 3'd4;

    localparam logic [15:0] POWER_UP_RST  = 16'd34000;
    localparam logic [7:0]  SETUP_RST     = 8'd1;
    localparam logic [7:0]  PULSE_RST     = 8'd5;
    localparam logic [15:0] SETTLE_RST    = 16'd5500;
    localparam logic [7:0]  CHAR_XTRA_RST = 8'd5;

    localparam logic [3:0] NIBBLE_WAKE  = 4'h3;
    localparam logic [3:0] NIBBLE_4BIT  = 4'h2;

    typedef struct packed {
        logic [15:0] power_up_wait_us;
        logic [7:0]  setup_wait_us;
        logic [7:0]  enable_pulse_us;
        logic [15:0] settle_wait_us;
        logic [7:0]  char_extra_wait_us;
    } lcdns_cfg_t;

    typedef struct packed {
        logic [3:0] data_nibble;
        logic       enable_pin;
        logic       register_select;
        logic       ready_res;
        logic       rejected;
    } lcdns_res_t;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] b;
        unique case (row)
            2'd0: b = 8'h80;
            2'd1: b = 8'hC0;
            2'd2: b = 8'h94;
            2'd3: b = 8'hD4;
            default: b = 8'h80;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h28;
            2'd1: c = 8'h10;
            2'd2: c = 8'h01;
            2'd3: c = 8'h0F;
            default: c = 8'h28;
        endcase
        return c;
    endfunction

endpackage

### src/char_lcd_nibble_write_sequencer_top.sv
// The result beat of an input beat is registered and appears in the cycle after the beat is accepted.
// Throughput: one input beat per cycle while m_ready is high; the result register frees as it is taken.
// Each input beat is one microsecond tick of the sequencer's wait counter.
// Reset (aresetn low, synchronous): sequencer idle with ready_res high, pins low,
// m_valid low, registers at defaults.
module char_lcd_nibble_write_sequencer_top import lcdns_pkg::*; #(
    parameter int INIT_WAKE_REPEATS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [7:0]  s_byte_value,
    input  logic [1:0]  s_row,
    input  logic [4:0]  s_column,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_data_nibble,
    output logic        m_enable_pin,
    output logic        m_register_select,
    output logic        m_ready_res,
    output logic        m_rejected
);

    lcdns_cfg_t cfg_reg;
    lcdns_res_t res;
    logic       m_valid_reg;
    logic       accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_up_wait_us   <= POWER_UP_RST;
            cfg_reg.setup_wait_us      <= SETUP_RST;
            cfg_reg.enable_pulse_us    <= PULSE_RST;
            cfg_reg.settle_wait_us     <= SETTLE_RST;
            cfg_reg.char_extra_wait_us <= CHAR_XTRA_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_POWER_UP:  cfg_reg.power_up_wait_us   <= cfg_data;
                CFG_SETUP:     cfg_reg.setup_wait_us      <= cfg_data[7:0];
                CFG_PULSE:     cfg_reg.enable_pulse_us    <= cfg_data[7:0];
                CFG_SETTLE:    cfg_reg.settle_wait_us     <= cfg_data;
                CFG_CHAR_XTRA: cfg_reg.char_extra_wait_us <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    lcdns_core #(
        .INIT_WAKE_REPEATS(INIT_WAKE_REPEATS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (accept),
        .opcode     (s_opcode),
        .byte_value (s_byte_value),
        .row        (s_row),
        .column     (s_column),
        .cfg        (cfg_reg),
        .res        (res)
    );

    assign m_valid           = m_valid_reg;
    assign m_data_nibble     = res.data_nibble;
    assign m_enable_pin      = res.enable_pin;
    assign m_register_select = res.register_select;
    assign m_ready_res       = res.ready_res;
    assign m_rejected        = res.rejected;

endmodule

### src/lcdns_core.sv
module lcdns_core import lcdns_pkg::*; #(
    parameter int INIT_WAKE_REPEATS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [2:0]  opcode,
    input  logic [7:0]  byte_value,
    input  logic [1:0]  row,
    input  logic [4:0]  column,
    input  lcdns_cfg_t  cfg,
    output lcdns_res_t  res
);

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_POWER      = 4'd1;
    localparam logic [3:0] PH_SETUP_INIT = 4'd2;
    localparam logic [3:0] PH_PULSE_INIT = 4'd3;
    localparam logic [3:0] PH_SETUP_HI   = 4'd4;
    localparam logic [3:0] PH_PULSE_HI   = 4'd5;
    localparam logic [3:0] PH_SETUP_LO   = 4'd6;
    localparam logic [3:0] PH_PULSE_LO   = 4'd7;
    localparam logic [3:0] PH_CHAR_EXTRA = 4'd8;
    localparam logic [3:0] PH_SETTLE     = 4'd9;

    localparam logic [3:0] REPS = 4'(INIT_WAKE_REPEATS);

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] wait_reg, wait_next;
    logic [7:0]  byte_reg, byte_next;
    logic [3:0]  step_reg, step_next;
    logic        chr_reg, chr_next;
    logic [3:0]  nib_reg, nib_next;
    logic        en_reg, en_next;
    logic        sel_reg, sel_next;
    logic        rej_reg, rej_next;

    always_comb begin
        logic       do_byte;
        logic [7:0] b_val;
        logic       b_chr;
        logic       do_init;
        logic [3:0] s;
        logic [3:0] cmd_off;

        do_byte    = 1'b0;
        b_val      = byte_value;
        b_chr      = 1'b0;
        do_init    = 1'b0;
        s          = step_reg;
        cmd_off    = 4'd0;
        phase_next = phase_reg;
        wait_next  = wait_reg;
        byte_next  = byte_reg;
        step_next  = step_reg;
        chr_next   = chr_reg;
        nib_next   = nib_reg;
        en_next    = en_reg;
        sel_next   = sel_reg;
        rej_next   = 1'b0;

        if (phase_reg == PH_IDLE) begin
            unique case (opcode)
                OP_INIT: begin
                    step_next  = 4'd0;
                    phase_next = PH_POWER;
                    wait_next  = cfg.power_up_wait_us;
                end
                OP_CMD: begin
                    do_byte = 1'b1;
                end
                OP_CHAR: begin
                    do_byte = 1'b1;
                    b_chr   = 1'b1;
                end
                OP_POS: begin
                    do_byte = 1'b1;
                    b_val   = row_base(row) + {3'd0, column};
                end
                default: ;
            endcase
        end else begin
            rej_next = (opcode == OP_INIT) || (opcode == OP_CMD) ||
                       (opcode == OP_CHAR) || (opcode == OP_POS);
            if (wait_reg != 16'd0) begin
                wait_next = wait_reg - 16'd1;
            end else begin
                unique case (phase_reg)
                    PH_POWER: begin
                        s       = 4'd1;
                        do_init = 1'b1;
                    end
                    PH_SETUP_INIT: begin
                        en_next    = 1'b1;
                        phase_next = PH_PULSE_INIT;
                        wait_next  = {8'd0, cfg.enable_pulse_us};
                    end
                    PH_SETUP_HI: begin
                        en_next    = 1'b1;
                        phase_next = PH_PULSE_HI;
                        wait_next  = {8'd0, cfg.enable_pulse_us};
                    end
                    PH_SETUP_LO: begin
                        en_next    = 1'b1;
                        phase_next = PH_PULSE_LO;
                        wait_next  = {8'd0, cfg.enable_pulse_us};
                    end
                    PH_PULSE_INIT: begin
                        en_next    = 1'b0;
                        phase_next = PH_SETTLE;
                        wait_next  = cfg.settle_wait_us;
                    end
                    PH_PULSE_HI: begin
                        en_next    = 1'b0;
                        nib_next   = byte_reg[3:0];
                        phase_next = PH_SETUP_LO;
                        wait_next  = {8'd0, cfg.setup_wait_us};
                    end
                    PH_PULSE_LO: begin
                        en_next = 1'b0;
                        if (chr_reg) begin
                            phase_next = PH_CHAR_EXTRA;
                            wait_next  = {8'd0, cfg.char_extra_wait_us};
                        end else begin
                            phase_next = PH_SETTLE;
                            wait_next  = cfg.settle_wait_us;
                        end
                    end
                    PH_CHAR_EXTRA: begin
                        phase_next = PH_SETTLE;
                        wait_next  = cfg.settle_wait_us;
                    end
                    PH_SETTLE: begin
                        if (step_reg == 4'd0) begin
                            phase_next = PH_IDLE;
                            wait_next  = 16'd0;
                        end else begin
                            s       = step_reg + 4'd1;
                            do_init = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        wait_next  = 16'd0;
                    end
                endcase
            end
        end

        if (do_init) begin
            step_next = s;
            cmd_off   = s - REPS - 4'd2;
            priority if (s >= 4'd1 && s <= REPS) begin
                sel_next   = 1'b0;
                nib_next   = NIBBLE_WAKE;
                en_next    = 1'b0;
                phase_next = PH_SETUP_INIT;
                wait_next  = {8'd0, cfg.setup_wait_us};
            end else if (s == REPS + 4'd1) begin
                sel_next   = 1'b0;
                nib_next   = NIBBLE_4BIT;
                en_next    = 1'b0;
                phase_next = PH_SETUP_INIT;
                wait_next  = {8'd0, cfg.setup_wait_us};
            end else if (s >= REPS + 4'd2 && s <= REPS + 4'd5) begin
                do_byte = 1'b1;
                b_val   = init_cmd(cmd_off[1:0]);
                b_chr   = 1'b0;
            end else begin
                step_next  = 4'd0;
                phase_next = PH_IDLE;
                wait_next  = 16'd0;
            end
        end

        if (do_byte) begin
            byte_next  = b_val;
            chr_next   = b_chr;
            sel_next   = b_chr;
            nib_next   = b_val[7:4];
            en_next    = 1'b0;
            phase_next = PH_SETUP_HI;
            wait_next  = {8'd0, cfg.setup_wait_us};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            wait_reg  <= 16'd0;
            byte_reg  <= 8'd0;
            step_reg  <= 4'd0;
            chr_reg   <= 1'b0;
            nib_reg   <= 4'd0;
            en_reg    <= 1'b0;
            sel_reg   <= 1'b0;
            rej_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            byte_reg  <= byte_next;
            step_reg  <= step_next;
            chr_reg   <= chr_next;
            nib_reg   <= nib_next;
            en_reg    <= en_next;
            sel_reg   <= sel_next;
            rej_reg   <= rej_next;
        end
    end

    assign res.data_nibble     = nib_reg;
    assign res.enable_pin      = en_reg;
    assign res.register_select = sel_reg;
    assign res.ready_res       = (phase_reg == PH_IDLE);
    assign res.rejected        = rej_reg;

    a_no_reject_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_IDLE |=> !rej_reg)
        else $error("request rejected while idle");

    a_enable_in_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        en_reg |-> (phase_reg == PH_PULSE_INIT || phase_reg == PH_PULSE_HI ||
                    phase_reg == PH_PULSE_LO))
        else $error("enable high outside a pulse phase");

    a_idle_no_init_step: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> step_reg == 4'd0)
        else $error("init step left set in idle");

endmodule

### test/char_lcd_nibble_write_sequencer_top_tb.sv
module char_lcd_nibble_write_sequencer_top_tb;
    import lcdns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAKE_REPEATS = 4;
    localparam int QUIET_LIMIT = 500;
    localparam int RANDOM_ROUNDS = 4;
    localparam int ROUND_BEATS = 180;
    localparam int TICK_BATCH = 8;
    localparam logic [31:0] ROW_BASES = 32'h80_C0_94_D4;
    localparam logic [31:0] INIT_BYTES = 32'h28_10_01_0F;

    typedef enum logic [3:0] {
        ST_IDLE, ST_POWER_WAIT, ST_INIT_SETUP, ST_INIT_STROBE, ST_HI_SETUP,
        ST_HI_STROBE, ST_LO_SETUP, ST_LO_STROBE, ST_CHAR_HOLD, ST_SETTLE
    } lcd_phase_t;

    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        logic [1:0] row;
        logic [4:0] col;
        int         gap;
    } lcd_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode = '0;
    logic [7:0]  s_byte_value = '0;
    logic [1:0]  s_row = '0;
    logic [4:0]  s_column = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_data_nibble;
    logic        m_enable_pin;
    logic        m_register_select;
    logic        m_ready_res;
    logic        m_rejected;

    char_lcd_nibble_write_sequencer_top #(
        .INIT_WAKE_REPEATS(WAKE_REPEATS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_byte_value(s_byte_value),
        .s_row(s_row),
        .s_column(s_column),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data_nibble(m_data_nibble),
        .m_enable_pin(m_enable_pin),
        .m_register_select(m_register_select),
        .m_ready_res(m_ready_res),
        .m_rejected(m_rejected)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lcdns_cfg_t lcd_cfg;
    lcd_phase_t lcd_phase;
    logic [15:0] lcd_count;
    logic [7:0]  lcd_byte;
    logic        lcd_rs_held;
    logic [3:0]  lcd_step;
    logic        lcd_is_char;
    logic [3:0]  pin_nibble;
    logic        pin_en;
    logic        pin_rs;

    lcd_req_t   pending[$];
    lcdns_res_t pins_due[$];
    lcd_req_t   next_req;
    lcdns_res_t want_pins;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic rx_calm = 1'b1;
    int   tx_count = 0;
    int   rx_count = 0;
    int   rx_target = 0;
    int   quiet = 0;
    int   errors = 0;
    int   queued = 0;
    int   results_seen = 0;
    int   beats_in = 0;
    int   started = 0;
    int   turned_away = 0;
    int   settings = 1;

    function automatic void load_phase(lcd_phase_t ph, logic [15:0] w);
        lcd_phase = ph;
        lcd_count = w;
    endfunction

    function automatic void begin_byte(logic [7:0] b, logic rs, logic is_char);
        lcd_byte = b;
        lcd_rs_held = rs;
        lcd_is_char = is_char;
        pin_rs = rs;
        pin_nibble = b[7:4];
        pin_en = 1'b0;
        load_phase(ST_HI_SETUP, {8'h00, lcd_cfg.setup_wait_us});
    endfunction

    function automatic void begin_init_nibble(logic [3:0] n);
        pin_rs = 1'b0;
        pin_nibble = n;
        pin_en = 1'b0;
        load_phase(ST_INIT_SETUP, {8'h00, lcd_cfg.setup_wait_us});
    endfunction

    function automatic void next_init_step();
        int st;
        int idx;
        st = int'(lcd_step);
        idx = st - WAKE_REPEATS - 2;
        if (st >= 1 && st <= WAKE_REPEATS) begin
            begin_init_nibble(NIBBLE_WAKE);
        end else if (st == WAKE_REPEATS + 1) begin
            begin_init_nibble(NIBBLE_4BIT);
        end else if (st >= WAKE_REPEATS + 2 && st <= WAKE_REPEATS + 5) begin
            begin_byte(INIT_BYTES[8 * (3 - idx) +: 8], 1'b0, 1'b0);
        end else begin
            lcd_step = 4'd0;
            load_phase(ST_IDLE, 16'd0);
        end
    endfunction

    function automatic void lcd_reset();
        lcd_cfg.power_up_wait_us = POWER_UP_RST;
        lcd_cfg.setup_wait_us = SETUP_RST;
        lcd_cfg.enable_pulse_us = PULSE_RST;
        lcd_cfg.settle_wait_us = SETTLE_RST;
        lcd_cfg.char_extra_wait_us = CHAR_XTRA_RST;
        lcd_phase = ST_IDLE;
        lcd_count = '0;
        lcd_byte = '0;
        lcd_rs_held = 1'b0;
        lcd_step = '0;
        lcd_is_char = 1'b0;
        pin_nibble = '0;
        pin_en = 1'b0;
        pin_rs = 1'b0;
    endfunction

    function automatic lcdns_res_t lcd_tick(logic [2:0] op, logic [7:0] b, logic [1:0] row,
                                            logic [4:0] col);
        lcdns_res_t r;
        logic busy_req;
        logic [7:0] pos_byte;
        busy_req = 1'b0;
        pos_byte = ROW_BASES[8 * (3 - int'(row)) +: 8] + {3'b000, col};
        if (lcd_phase == ST_IDLE) begin
            case (op)
                OP_INIT: begin
                    lcd_step = 4'd0;
                    load_phase(ST_POWER_WAIT, lcd_cfg.power_up_wait_us);
                end
                OP_CMD: begin_byte(b, 1'b0, 1'b0);
                OP_CHAR: begin_byte(b, 1'b1, 1'b1);
                OP_POS: begin_byte(pos_byte, 1'b0, 1'b0);
                default: ;
            endcase
        end else begin
            busy_req = (op >= OP_INIT && op <= OP_POS);
            if (lcd_count != 16'd0) begin
                lcd_count = lcd_count - 16'd1;
            end else begin
                case (lcd_phase)
                    ST_POWER_WAIT: begin
                        lcd_step = 4'd1;
                        next_init_step();
                    end
                    ST_INIT_SETUP: begin
                        pin_en = 1'b1;
                        load_phase(ST_INIT_STROBE, {8'h00, lcd_cfg.enable_pulse_us});
                    end
                    ST_HI_SETUP: begin
                        pin_en = 1'b1;
                        load_phase(ST_HI_STROBE, {8'h00, lcd_cfg.enable_pulse_us});
                    end
                    ST_LO_SETUP: begin
                        pin_en = 1'b1;
                        load_phase(ST_LO_STROBE, {8'h00, lcd_cfg.enable_pulse_us});
                    end
                    ST_INIT_STROBE: begin
                        pin_en = 1'b0;
                        load_phase(ST_SETTLE, lcd_cfg.settle_wait_us);
                    end
                    ST_HI_STROBE: begin
                        pin_en = 1'b0;
                        pin_nibble = lcd_byte[3:0];
                        load_phase(ST_LO_SETUP, {8'h00, lcd_cfg.setup_wait_us});
                    end
                    ST_LO_STROBE: begin
                        pin_en = 1'b0;
                        if (lcd_is_char) begin
                            load_phase(ST_CHAR_HOLD, {8'h00, lcd_cfg.char_extra_wait_us});
                        end else begin
                            load_phase(ST_SETTLE, lcd_cfg.settle_wait_us);
                        end
                    end
                    ST_CHAR_HOLD: load_phase(ST_SETTLE, lcd_cfg.settle_wait_us);
                    ST_SETTLE: begin
                        if (lcd_step == 4'd0) begin
                            load_phase(ST_IDLE, 16'd0);
                        end else begin
                            lcd_step = lcd_step + 4'd1;
                            next_init_step();
                        end
                    end
                    default: load_phase(ST_IDLE, 16'd0);
                endcase
            end
        end
        r.data_nibble = pin_nibble;
        r.enable_pin = pin_en;
        r.register_select = pin_rs;
        r.ready_res = (lcd_phase == ST_IDLE);
        r.rejected = busy_req;
        return r;
    endfunction

    function automatic void match(string field, logic [3:0] exp_v, logic [3:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, got_v);
            errors++;
        end
    endfunction

    function automatic void post(logic [2:0] op, logic [7:0] data, logic [1:0] row,
                                 logic [4:0] col, int gap_max);
        lcd_req_t r;
        r.op = op;
        r.data = data;
        r.row = row;
        r.col = col;
        r.gap = (gap_max == 0) ? 0 : int'($urandom_range(0, gap_max));
        pending.push_back(r);
        queued++;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (pending.size() == 0) begin
                s_valid <= 1'b0;
            end else if (tx_count < pending[0].gap) begin
                tx_count++;
                s_valid <= 1'b0;
            end else begin
                next_req = pending.pop_front();
                tx_count = 0;
                s_valid <= 1'b1;
                s_opcode <= next_req.op;
                s_byte_value <= next_req.data;
                s_row <= next_req.row;
                s_column <= next_req.col;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken) begin
                rx_count = 0;
                rx_target = rx_calm ? 0 : int'($urandom_range(0, 18));
            end
            if (rx_count < rx_target) begin
                rx_count++;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            in_taken <= s_valid && s_ready;
            out_taken <= m_valid && m_ready;
            if (s_valid && s_ready) begin
                if (lcd_phase == ST_IDLE && s_opcode >= OP_INIT && s_opcode <= OP_POS) begin
                    started++;
                end
                pins_due.push_back(lcd_tick(s_opcode, s_byte_value, s_row, s_column));
                beats_in++;
                if (pins_due[$].rejected) begin
                    turned_away++;
                end
            end
            if (m_valid && m_ready) begin
                if (pins_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, nibble %0d", $time,
                             m_data_nibble);
                    errors++;
                end else begin
                    want_pins = pins_due.pop_front();
                    results_seen++;
                    match("data_nibble", want_pins.data_nibble, m_data_nibble);
                    match("enable_pin", {3'b000, want_pins.enable_pin}, {3'b000, m_enable_pin});
                    match("register_select", {3'b000, want_pins.register_select},
                          {3'b000, m_register_select});
                    match("ready_res", {3'b000, want_pins.ready_res}, {3'b000, m_ready_res});
                    match("rejected", {3'b000, want_pins.rejected}, {3'b000, m_rejected});
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("%0t: no beat moved for %0d cycles", $time, quiet);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    task automatic wait_drained();
        @(negedge aclk);
        while (results_seen != queued) begin
            @(negedge aclk);
        end
    endtask

    task automatic run_to_idle();
        wait_drained();
        while (lcd_phase != ST_IDLE) begin
            repeat (TICK_BATCH) post(OP_TICK, 8'($urandom), 2'($urandom), 5'($urandom), 0);
            wait_drained();
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_POWER_UP: lcd_cfg.power_up_wait_us = val;
            CFG_SETUP: lcd_cfg.setup_wait_us = val[7:0];
            CFG_PULSE: lcd_cfg.enable_pulse_us = val[7:0];
            CFG_SETTLE: lcd_cfg.settle_wait_us = val;
            CFG_CHAR_XTRA: lcd_cfg.char_extra_wait_us = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(logic [15:0] pw, logic [7:0] su, logic [7:0] pu,
                             logic [15:0] se, logic [7:0] ch);
        write_reg(CFG_POWER_UP, pw);
        write_reg(CFG_SETUP, {8'($urandom), su});
        write_reg(CFG_PULSE, {8'($urandom), pu});
        write_reg(CFG_SETTLE, se);
        write_reg(CFG_CHAR_XTRA, {8'($urandom), ch});
        write_reg(3'($urandom_range(7, int'(CFG_CHAR_XTRA) + 1)), 16'($urandom));
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic single(logic [2:0] op, logic [7:0] b, logic [1:0] row, logic [4:0] col);
        post(op, b, row, col, 18);
        run_to_idle();
    endtask

    initial begin
        int pick;
        int gap_max;
        int byte_len;
        int len;
        int round_start;
        logic paused;
        logic [2:0] op;
        logic [4:0] col;

        lcd_reset();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset timing into the character hold, a request landing while busy, then short waits
        post(OP_CHAR, 8'h5A, 2'd3, 5'd19, 0);
        post(OP_CMD, 8'hA5, 2'd0, 5'd0, 0);
        repeat (19) post(OP_TICK, 8'($urandom), 2'($urandom), 5'($urandom), 0);
        wait_drained();
        apply_cfg(16'd2, 8'd1, 8'd2, 16'd1, 8'd1);
        run_to_idle();
        single(OP_INIT, 8'h00, 2'd0, 5'd0);

        apply_cfg(16'd0, 8'd0, 8'd1, 16'd0, 8'd0);
        rx_calm = 1'b0;
        post(OP_INIT, 8'h00, 2'd0, 5'd0, 18);
        post(OP_CMD, 8'h33, 2'd1, 5'd2, 18);
        post(OP_CHAR, 8'hCC, 2'd2, 5'd5, 0);
        post(OP_POS, 8'h0F, 2'd3, 5'd31, 0);
        post(OP_INIT, 8'hF0, 2'd0, 5'd0, 0);
        post(3'(int'(OP_POS) + 1), 8'hFF, 2'd3, 5'd31, 0);
        run_to_idle();
        single(OP_CMD, 8'h00, 2'd0, 5'd0);
        single(OP_CMD, 8'hFF, 2'd3, 5'd31);
        single(OP_CHAR, 8'h00, 2'd0, 5'd0);
        single(OP_CHAR, 8'hFF, 2'd0, 5'd0);
        single(OP_POS, 8'h00, 2'd0, 5'd0);
        single(OP_POS, 8'hFF, 2'd1, 5'd19);
        single(OP_POS, 8'h00, 2'd2, 5'd10);
        single(OP_POS, 8'h00, 2'd3, 5'd31);
        for (int k = int'(OP_POS) + 1; k < 8; k++) begin
            single(3'(k), 8'($urandom), 2'($urandom), 5'($urandom));
        end
        single(OP_TICK, 8'h00, 2'd0, 5'd0);

        rx_calm = 1'b1;
        apply_cfg(16'd0, 8'd0, 8'd1, 16'h0100, 8'h80);
        single(OP_CHAR, 8'hC3, 2'd0, 5'd0);

        for (int rnd = 0; rnd < RANDOM_ROUNDS; rnd++) begin
            run_to_idle();
            apply_cfg(16'($urandom_range(0, 60)), 8'($urandom_range(0, 3)),
                      8'($urandom_range(1, 4)), 16'($urandom_range(0, 12)),
                      8'($urandom_range(0, 4)));
            rx_calm = ($urandom_range(0, 3) == 0);
            round_start = queued;
            paused = 1'b0;
            while (queued - round_start < ROUND_BEATS) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) op = OP_TICK;
                else if (pick < 14) op = OP_INIT;
                else if (pick < 44) op = OP_CMD;
                else if (pick < 72) op = OP_CHAR;
                else if (pick < 94) op = OP_POS;
                else op = 3'($urandom_range(7, int'(OP_POS) + 1));
                col = 5'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 31 : 19));
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
                post(op, 8'($urandom), 2'($urandom), col, gap_max);
                byte_len = 2 * (int'(lcd_cfg.setup_wait_us) + int'(lcd_cfg.enable_pulse_us) + 2)
                           + int'(lcd_cfg.settle_wait_us) + 1;
                case (op)
                    OP_INIT: len = int'(lcd_cfg.power_up_wait_us) + 1
                                   + (WAKE_REPEATS + 1) * (int'(lcd_cfg.setup_wait_us)
                                   + int'(lcd_cfg.enable_pulse_us)
                                   + int'(lcd_cfg.settle_wait_us) + 3) + 4 * byte_len;
                    OP_CHAR: len = byte_len + int'(lcd_cfg.char_extra_wait_us) + 1;
                    OP_CMD, OP_POS: len = byte_len;
                    default: len = 1;
                endcase
                if ($urandom_range(0, 4) == 0) len = $urandom_range(0, len);
                else len = len + $urandom_range(0, 2);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        post(3'($urandom), 8'($urandom), 2'($urandom), 5'($urandom), gap_max);
                    end else begin
                        post(OP_TICK, 8'($urandom), 2'($urandom), 5'($urandom), gap_max);
                    end
                end
                if (!paused && queued - round_start > ROUND_BEATS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("covered %0d tick beats over %0d register settings, extremes included",
                 beats_in, settings);
        $display("requests started %0d, turned away while busy %0d, mismatches %0d",
                 started, turned_away, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
src/lcdns_pkg.sv
src/lcdns_core.sv
src/char_lcd_nibble_write_sequencer_top.sv
test/char_lcd_nibble_write_sequencer_top_tb.sv
